// ----- rtl/core/lcg48_pkg.sv -----
`default_nettype none

package lcg48_pkg;

  // Generator constants.
  localparam logic [47:0] LCG_MULT = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LCG_INC  = 48'd11;
  localparam logic [31:0] MULT_LO  = 32'hDEEC_E66D;
  localparam logic [31:0] MULT_HI  = 32'h0000_0005;

  // Request action codes.
  localparam logic [2:0] ACT_RESEED = 3'd0;
  localparam logic [2:0] ACT_INT32  = 3'd1;
  localparam logic [2:0] ACT_BOUND  = 3'd2;
  localparam logic [2:0] ACT_INT64  = 3'd3;
  localparam logic [2:0] ACT_BOOL   = 3'd4;
  localparam logic [2:0] ACT_FLOAT  = 3'd5;
  localparam logic [2:0] ACT_DOUBLE = 3'd6;

  // Control from the sequencer to the state update unit.
  typedef struct packed {
    logic start;
    logic load;
  } step_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/lcg48_step_unit.sv -----
`default_nettype none

module lcg48_step_unit (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  lcg48_pkg::step_req_t  req_i,
  input  wire  [47:0]           load_value_i,
  output logic                  done_o,
  output logic [47:0]           state_o
);
  import lcg48_pkg::*;

  logic [47:0] state_q, state_d;
  logic [47:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [1:0]  phase_q, phase_d;
  logic        active_q, active_d;
  logic [31:0] mul_a, mul_b;

  // Operand selection for the shared 32x32 multiplier.
  always_comb begin
    unique case (phase_q)
      2'd1: begin
        mul_a = {16'h0000, state_q[47:32]};
        mul_b = MULT_LO;
      end
      2'd2: begin
        mul_a = state_q[31:0];
        mul_b = MULT_HI;
      end
      default: begin
        mul_a = state_q[31:0];
        mul_b = MULT_LO;
      end
    endcase
  end

  // Partial products are accumulated one per cycle; the top bits wrap off.
  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    phase_d  = phase_q;
    active_d = active_q;
    prod_d   = mul_a * mul_b;
    if (req_i.load) begin
      state_d = load_value_i;
    end else if (req_i.start) begin
      active_d = 1'b1;
      phase_d  = 2'd0;
    end else if (active_q) begin
      phase_d = phase_q + 2'd1;
      unique case (phase_q)
        2'd0: acc_d = LCG_INC;
        2'd1: acc_d = acc_q + prod_q[47:0];
        2'd2: acc_d = acc_q + {prod_q[15:0], 32'h0000_0000};
        default: begin
          state_d  = acc_q + {prod_q[15:0], 32'h0000_0000};
          active_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= LCG_MULT;
      phase_q  <= 2'd0;
      active_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      active_q <= active_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign done_o  = active_q && (phase_q == 2'd3);
  assign state_o = state_q;

endmodule

`default_nettype wire

// ----- rtl/core/lcg48_divider.sv -----
`default_nettype none

module lcg48_divider (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [30:0] dividend_i,
  input  wire  [30:0] divisor_i,
  output logic        done_o,
  output logic [30:0] rem_o
);
  localparam int DivBits = 31;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [30:0] dvd_q, dvs_q, rem_q;
  logic [31:0] trial;
  logic [31:0] diff;
  logic        fits;
  logic [30:0] rem_next;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial    = {rem_q, dvd_q[30]};
  assign diff     = trial - {1'b0, dvs_q};
  assign fits     = trial >= {1'b0, dvs_q};
  assign rem_next = fits ? diff[30:0] : trial[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(DivBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[29:0], 1'b0};
      rem_q <= rem_next;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/lcg48_random_generator_unit.sv -----
// 48-bit linear congruential random generator.
// Requests arrive on the in channel (in_valid_i/in_ready_o) with an action code
// and a bound; each request yields exactly one 64-bit result on the out channel
// (out_valid_o/out_ready_i). The seed register is written on the cfg channel,
// which is always ready; write it only while no request is in flight.
// One request is worked at a time; in_ready_o is high only while the sequencer
// is idle. Each state advance runs on the shared 32x32 multiplier. Reseed and
// the unused code go straight to finish; single draws take one advance and
// two-part draws two. A bounded draw with a power-of-two bound takes one advance
// and one scaling multiply. Any other bound, when the first draw is kept, takes
// an advance, a step to take the draw and a run on the bit-serial divider (31
// remainder steps and a done strobe). Each rejected draw adds another advance
// and another division.
// Reset puts the seed to zero and the state to that seed scrambled with the
// multiplier. A finished result waits in the output register while the receiver
// stalls; a new request may be taken meanwhile, and its result is held back in
// the sequencer until the output register is free.
`default_nettype none

module lcg48_random_generator_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [47:0] cfg_seed_value_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  action_i,
  input  wire  [30:0] bound_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [63:0] value_o
);
  import lcg48_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STEP   = 3'd1;
  localparam logic [2:0] ST_DRAW   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [47:0] seed_q;
  logic [2:0]  action_q, action_d;
  logic [30:0] bound_q, bound_d;
  logic [30:0] r_q, r_d;
  logic [31:0] hi_q, hi_d;
  logic        second_q, second_d;
  logic [63:0] res_q, res_d;
  logic        out_valid_q;
  logic [63:0] out_value_q;
  logic        out_load;

  step_req_t   step_req;
  logic        step_done;
  logic [47:0] lcg_state;
  logic        div_start;
  logic        div_done;
  logic [30:0] div_rem;
  logic [61:0] pw_prod;
  logic [31:0] reject_sum;
  logic        bound_pow2;

  lcg48_step_unit u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (step_req),
    .load_value_i (seed_q ^ LCG_MULT),
    .done_o       (step_done),
    .state_o      (lcg_state)
  );

  // The divider captures the draw in the same cycle that it is taken.
  lcg48_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (r_d),
    .divisor_i  (bound_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Seed register write.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_seed_value_i;
    end
  end

  // Bounded draw helpers: power-of-two scaling and the rejection test.
  assign bound_pow2 = (bound_q & (bound_q - 31'd1)) == 31'd0;
  assign pw_prod    = {31'b0, r_q} * {31'b0, bound_q};
  assign reject_sum = {1'b0, r_q} - {1'b0, div_rem} + {1'b0, bound_q} - 32'd1;

  assign in_ready_o = (st_q == ST_IDLE);

  // Request sequencer.
  always_comb begin
    st_d           = st_q;
    action_d       = action_q;
    bound_d        = bound_q;
    r_d            = r_q;
    hi_d           = hi_q;
    second_d       = second_q;
    res_d          = res_q;
    step_req.start = 1'b0;
    step_req.load  = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          action_d = action_i;
          bound_d  = bound_i;
          second_d = 1'b0;
          priority if (action_i == ACT_RESEED) begin
            step_req.load = 1'b1;
            res_d         = '0;
            st_d          = ST_FINISH;
          end else if (action_i == ACT_INT32 || action_i == ACT_BOUND ||
                       action_i == ACT_INT64 || action_i == ACT_BOOL ||
                       action_i == ACT_FLOAT || action_i == ACT_DOUBLE) begin
            step_req.start = 1'b1;
            st_d           = ST_STEP;
          end else begin
            res_d = '0;
            st_d  = ST_FINISH;
          end
        end
      end
      ST_STEP: begin
        if (step_done) begin
          st_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        st_d = ST_FINISH;
        unique case (action_q)
          ACT_INT32: res_d = {{32{lcg_state[47]}}, lcg_state[47:16]};
          ACT_INT64: begin
            if (!second_q) begin
              hi_d           = lcg_state[47:16];
              second_d       = 1'b1;
              step_req.start = 1'b1;
              st_d           = ST_STEP;
            end else begin
              res_d = {hi_q, 32'h0000_0000} + {{32{lcg_state[47]}}, lcg_state[47:16]};
            end
          end
          ACT_BOOL:  res_d = {63'b0, lcg_state[47]};
          ACT_FLOAT: res_d = {40'b0, lcg_state[47:24]};
          ACT_DOUBLE: begin
            if (!second_q) begin
              hi_d           = {6'b0, lcg_state[47:22]};
              second_d       = 1'b1;
              step_req.start = 1'b1;
              st_d           = ST_STEP;
            end else begin
              res_d = {11'b0, hi_q[25:0], lcg_state[47:21]};
            end
          end
          ACT_BOUND: begin
            r_d = lcg_state[47:17];
            if (bound_pow2) begin
              st_d = ST_MUL;
            end else begin
              div_start = 1'b1;
              st_d      = ST_DIV;
            end
          end
          default: res_d = '0;
        endcase
      end
      ST_MUL: begin
        res_d = {33'b0, pw_prod[61:31]};
        st_d  = ST_FINISH;
      end
      ST_DIV: begin
        if (div_done) begin
          if (reject_sum[31]) begin
            step_req.start = 1'b1;
            st_d           = ST_STEP;
          end else begin
            res_d = {33'b0, div_rem};
            st_d  = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    bound_q  <= bound_d;
    r_q      <= r_d;
    hi_q     <= hi_d;
    res_q    <= res_d;
  end

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

`ifndef SYNTHESIS
  // An accepted request always takes the sequencer out of idle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer still ready after accepting a request");

  // The state update unit only finishes while the sequencer waits for it.
  a_step_done_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_done |-> st_q == ST_STEP)
    else $error("state update finished outside the step wait");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> st_q == ST_DIV)
    else $error("divider finished outside the remainder wait");

  // A finished result with a free output register is presented next cycle.
  a_finish_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FINISH) && !out_valid_q |=> out_valid_q && (st_q == ST_IDLE))
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

// ----- tb/lcg48_draw_checker.sv -----
// Watches the seed, request and result channels of the generator, keeps its own
// copy of the 48-bit state, and checks every result against the oldest predicted draw.
module lcg48_draw_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_i,
  input  wire  [47:0] cfg_seed_value_i,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [2:0]  action_i,
  input  wire  [30:0] bound_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [63:0] value_i,
  output int          mismatches_o,
  output int          awaiting_o
);
  import lcg48_pkg::*;

  typedef struct packed {
    logic [2:0]  action;
    logic [30:0] bound;
    logic [63:0] value;
  } draw_t;

  logic [47:0] gen_state = LCG_MULT;
  logic [47:0] seed_reg = '0;
  draw_t       predicted_draws[$];
  int          mismatch_count = 0;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // Advances the state by one step and returns its top k bits.
  function automatic logic [31:0] take_bits(input int unsigned k);
    logic [47:0] top_bits;
    gen_state = gen_state * LCG_MULT + LCG_INC;
    top_bits = gen_state >> (48 - k);
    return top_bits[31:0];
  endfunction

  function automatic logic [63:0] sext32(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  // Draw below a limit: a power of two (or zero) scales one 31-bit draw, any other
  // limit takes the remainder and retries while the draw falls in the biased top range.
  function automatic logic [63:0] bounded_value(input logic [30:0] limit);
    logic [63:0] lim;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] span;
    lim = {33'd0, limit};
    if ((lim & (~lim + 64'd1)) == lim) begin
      r = {32'd0, take_bits(31)};
      return (r * lim) >> 31;
    end
    do begin
      r = {32'd0, take_bits(31)};
      m = r % lim;
      span = r - m + lim - 64'd1;
    end while (span[31]);
    return m;
  endfunction

  // Works out the value of one request and moves the state on.
  function automatic logic [63:0] predict_draw(input logic [2:0] act,
                                               input logic [30:0] limit);
    logic [63:0] hi;
    logic [63:0] v;
    v = '0;
    case (act)
      ACT_RESEED: gen_state = seed_reg ^ LCG_MULT;
      ACT_INT32:  v = sext32(take_bits(32));
      ACT_BOUND:  v = bounded_value(limit);
      ACT_INT64: begin
        hi = sext32(take_bits(32));
        v = (hi << 32) + sext32(take_bits(32));
      end
      ACT_BOOL:   v = {32'd0, take_bits(1)};
      ACT_FLOAT:  v = {32'd0, take_bits(24)};
      ACT_DOUBLE: begin
        hi = {32'd0, take_bits(26)};
        v = (hi << 27) + {32'd0, take_bits(27)};
      end
      default:    v = '0;
    endcase
    return v;
  endfunction

  // Every transfer is taken from the values present at the clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    draw_t head;
    draw_t req;
    if (!rst_ni) begin
      seed_reg = '0;
      gen_state = LCG_MULT;
      predicted_draws.delete();
      awaiting_o <= 0;
    end else begin
      // A result transfer is compared with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (predicted_draws.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with no request outstanding",
                                    value_i));
        end else begin
          head = predicted_draws.pop_front();
          if (value_i !== head.value)
            report_mismatch($sformatf("action %0d bound %0d: value %h, predicted %h",
                                      head.action, head.bound, value_i, head.value));
        end
      end
      if (cfg_valid_i && cfg_ready_i)
        seed_reg = cfg_seed_value_i;
      // A request transfer is predicted at once.
      if (in_valid_i && in_ready_i) begin
        req.action = action_i;
        req.bound = bound_i;
        req.value = predict_draw(action_i, bound_i);
        predicted_draws.push_back(req);
      end
      awaiting_o <= predicted_draws.size();
    end
  end

  assign mismatches_o = mismatch_count;

endmodule

// ----- tb/lcg48_random_generator_unit_tb.sv -----
// Drives requests and seed writes into the generator and gives the verdict.
module lcg48_random_generator_unit_tb;
  import lcg48_pkg::*;

  localparam logic [2:0] ACT_UNUSED      = 3'd7;
  localparam int         RANDOM_PHASES   = 10;
  localparam int         PHASE_ITEMS     = 73;
  localparam int         STEADY_PHASE    = 3;
  localparam int         PRESSURE_PHASE  = 6;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         DRAIN_CYCLES    = 60;
  localparam int         RUN_LIMIT       = 8_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic [47:0] cfg_seed_value_i;
  logic        in_valid_i;
  logic [2:0]  action_i;
  logic [30:0] bound_i;
  logic        out_ready_i;
  wire         cfg_ready_o;
  wire         in_ready_o;
  wire         out_valid_o;
  wire  [63:0] value_o;
  int          mismatches;
  int          awaiting;

  bit steady_mode = 1'b0;
  bit hold_off_req = 1'b0;
  int sent_count = 0;
  int bound_count = 0;
  int reseed_count = 0;
  int seed_writes = 0;

  lcg48_random_generator_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_seed_value_i (cfg_seed_value_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .bound_i          (bound_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o)
  );

  lcg48_draw_checker draw_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_seed_value_i (cfg_seed_value_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .action_i         (action_i),
    .bound_i          (bound_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_i          (value_o),
    .mismatches_o     (mismatches),
    .awaiting_o       (awaiting)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Result receiver: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= steady_mode || ($urandom_range(99) >= 20);
      end
    end
  end

  // Offers one request and holds it until the transfer, then maybe idles.
  task automatic send_request(input logic [2:0] act, input logic [30:0] limit);
    in_valid_i <= 1'b1;
    action_i <= act;
    bound_i <= limit;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    if (act == ACT_BOUND)
      bound_count++;
    if (act == ACT_RESEED)
      reseed_count++;
    if (!steady_mode && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [47:0] seed);
    cfg_valid_i <= 1'b1;
    cfg_seed_value_i <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    seed_writes++;
  endtask

  // Bounds weighted toward powers of two, tiny values, the top of the range and
  // limits just above 2^30, where almost half of the draws are rejected.
  function automatic logic [30:0] pick_bound();
    logic [30:0] b;
    case ($urandom_range(9))
      0:       b = $urandom_range(1) ? 31'd0 : 31'd1;
      1, 2:    b = 31'd1 << $urandom_range(30);
      3:       b = 31'($urandom_range(1, 16));
      4:       b = 31'h7FFF_FFFF - 31'($urandom_range(3));
      5:       b = 31'h4000_0000 + 31'($urandom_range(1, 1000));
      default: b = 31'($urandom());
    endcase
    return b;
  endfunction

  function automatic logic [2:0] pick_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6)
      return ACT_RESEED;
    if (r < 9)
      return ACT_UNUSED;
    if (r < 40)
      return ACT_BOUND;
    return 3'($urandom_range(ACT_INT32, ACT_DOUBLE));
  endfunction

  function automatic logic [47:0] random_seed();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  // Stimulus and verdict.
  initial begin
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_seed_value_i <= '0;
    in_valid_i <= 1'b0;
    action_i <= ACT_RESEED;
    bound_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Draws straight from the reset state, every action and the bound corners.
    send_request(ACT_INT32, 31'd5);
    send_request(ACT_BOOL, '0);
    send_request(ACT_FLOAT, 31'h7FFF_FFFF);
    send_request(ACT_DOUBLE, '0);
    send_request(ACT_INT64, '0);
    send_request(ACT_BOUND, 31'd1);
    send_request(ACT_BOUND, 31'd0);
    send_request(ACT_BOUND, 31'h4000_0000);
    send_request(ACT_BOUND, 31'h7FFF_FFFF);
    send_request(ACT_BOUND, 31'd3);
    send_request(ACT_BOUND, 31'h4000_0001);
    send_request(ACT_UNUSED, 31'h7FFF_FFFF);
    send_request(ACT_RESEED, '0);
    send_request(ACT_INT32, '0);

    // All-ones seed.
    quiesce();
    write_seed(48'hFFFF_FFFF_FFFF);
    send_request(ACT_RESEED, 31'h7FFF_FFFF);
    send_request(ACT_INT64, '0);
    send_request(ACT_DOUBLE, '0);
    send_request(ACT_BOUND, 31'h7FFF_FFFE);

    // A seed equal to the scrambling constant leaves the state at zero.
    quiesce();
    write_seed(LCG_MULT);
    send_request(ACT_RESEED, '0);
    send_request(ACT_INT32, '0);
    send_request(ACT_FLOAT, '0);

    // Random phases, each after a seed write (zero, all-ones or random).
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiesce();
      if (p % 4 == 0)
        write_seed(p % 8 == 0 ? 48'd0 : 48'hFFFF_FFFF_FFFF);
      else
        write_seed(random_seed());
      steady_mode = (p == STEADY_PHASE);
      if (p == PRESSURE_PHASE)
        hold_off_req = 1'b1;
      if ($urandom_range(1))
        send_request(ACT_RESEED, pick_bound());
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_request(pick_action(), pick_bound());
    end
    steady_mode = 1'b0;

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests (%0d bounded draws, %0d reseeds) under %0d seeds.",
             sent_count, bound_count, reseed_count, seed_writes);
    $display("It included a %0d-cycle result stall and a stretch with no idling.",
             HOLD_OFF_CYCLES);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
